>>> rtl/sms_pkg.sv
// shared types, constants and phase tables for the stepper move sequencer
package sms_pkg;

  localparam int DELAY_BITS    = 20;
  localparam int POSITION_BITS = 32;
  localparam int STEPS_BITS    = 31;
  localparam int PHASE_BITS    = 3;
  localparam int COIL_BITS     = 4;
  localparam int CFG_IDX_BITS  = 1;

  localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(2944);
  localparam logic [3:0] HALF_COUNT = 4'd8;
  localparam logic [3:0] FULL_COUNT = 4'd4;

  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_STEP = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY     = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_MOVE    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_LOAD    = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]                       op;
    logic signed [31:0]               move_steps;
    logic signed [POSITION_BITS-1:0]  new_position;
  } item_t;

  typedef struct packed {
    logic [COIL_BITS-1:0]             coils;
    logic signed [POSITION_BITS-1:0]  position_now;
    logic                             moving;
    logic                             status;
  } result_t;

  typedef struct packed {
    logic                  half_step_mode;
    logic [DELAY_BITS-1:0] step_delay_ticks;
  } cfg_t;

  localparam logic [COIL_BITS-1:0] HALF_TAB [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };
  localparam logic [COIL_BITS-1:0] FULL_TAB [4] = '{
    4'h3, 4'h6, 4'hC, 4'h9
  };

  // one phase forward or back, wrapping into the table of the current mode
  function automatic logic [PHASE_BITS-1:0] next_phase(
    input logic [PHASE_BITS-1:0] p,
    input logic                  dir,
    input logic                  half
  );
    logic [3:0] count;
    logic [3:0] up;
    logic [3:0] dn;
    logic [PHASE_BITS-1:0] res;
    count = half ? HALF_COUNT : FULL_COUNT;
    up = {1'b0, p} + 4'd1;
    dn = {1'b0, p} - 4'd1;
    if (!dir) begin
      res = (up >= count) ? '0 : up[PHASE_BITS-1:0];
    end else if (p == '0) begin
      res = 3'(count - 4'd1);
    end else begin
      res = (dn >= count) ? '0 : dn[PHASE_BITS-1:0];
    end
    return res;
  endfunction

  function automatic logic [COIL_BITS-1:0] coil_pattern(
    input logic [PHASE_BITS-1:0] p,
    input logic                  half
  );
    return half ? HALF_TAB[p] : FULL_TAB[p[1:0]];
  endfunction

endpackage

>>> rtl/sms_in_if.sv
// command channel: valid/ready plus one command beat
interface sms_in_if;
  logic             valid;
  logic             ready;
  logic [1:0]       op;
  logic signed [31:0] move_steps;
  logic signed [sms_pkg::POSITION_BITS-1:0] new_position;

  modport source (output valid, output op, output move_steps, output new_position,
                  input ready);
  modport sink   (input valid, input op, input move_steps, input new_position,
                  output ready);
endinterface

>>> rtl/sms_out_if.sv
// result channel: valid/ready plus one status beat
interface sms_out_if;
  logic             valid;
  logic             ready;
  logic [sms_pkg::COIL_BITS-1:0] coils;
  logic signed [sms_pkg::POSITION_BITS-1:0] position_now;
  logic             moving;
  logic             status;

  modport source (output valid, output coils, output position_now, output moving,
                  output status, input ready);
  modport sink   (input valid, input coils, input position_now, input moving,
                  input status, output ready);
endinterface

>>> rtl/sms_core.sv
// motor state registers and the per-command update logic
module sms_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  sms_pkg::item_t   item,
  input  sms_pkg::cfg_t    cfg,
  output sms_pkg::result_t res
);

  logic [sms_pkg::PHASE_BITS-1:0]           phase_r, phase_nxt;
  logic [sms_pkg::COIL_BITS-1:0]            coils_r, coils_nxt;
  logic signed [sms_pkg::POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [sms_pkg::STEPS_BITS-1:0]           steps_r, steps_nxt;
  logic [sms_pkg::DELAY_BITS-1:0]           delay_r, delay_nxt;
  logic                                     dir_r, dir_nxt;
  logic                                     busy_r, busy_nxt;
  logic                                     status;

  always_comb begin
    logic [sms_pkg::DELAY_BITS-1:0] reload;
    logic [sms_pkg::DELAY_BITS-1:0] dly_dec;
    logic [31:0]                    mag;
    logic                           step_dir;
    logic                           do_step;
    logic [sms_pkg::PHASE_BITS-1:0] p;

    phase_nxt = phase_r;
    coils_nxt = coils_r;
    pos_nxt   = pos_r;
    steps_nxt = steps_r;
    delay_nxt = delay_r;
    dir_nxt   = dir_r;
    busy_nxt  = busy_r;
    status    = 1'b0;
    do_step   = 1'b0;
    step_dir  = dir_r;

    // a zero delay setting counts as one tick
    reload  = (cfg.step_delay_ticks == '0) ? sms_pkg::DELAY_BITS'(1) : cfg.step_delay_ticks;
    dly_dec = (delay_r != '0) ? delay_r - sms_pkg::DELAY_BITS'(1) : delay_r;
    mag     = item.move_steps[31] ? (~item.move_steps + 32'd1) : item.move_steps;

    if (sms_pkg::op_t'(item.op) == sms_pkg::OP_TICK) begin
      if (busy_r) begin
        delay_nxt = dly_dec;
        if (dly_dec == '0) begin
          if (steps_r != '0) begin
            do_step   = 1'b1;
            steps_nxt = steps_r - sms_pkg::STEPS_BITS'(1);
            delay_nxt = reload;
          end else begin
            busy_nxt = 1'b0;
          end
        end
      end
    end else if (busy_r) begin
      status = 1'b1;
    end else begin
      case (sms_pkg::op_t'(item.op))
        sms_pkg::OP_MOVE: begin
          if (item.move_steps != '0) begin
            step_dir  = item.move_steps[31];
            dir_nxt   = item.move_steps[31];
            do_step   = 1'b1;
            steps_nxt = sms_pkg::STEPS_BITS'(mag - 32'd1);
            delay_nxt = reload;
            busy_nxt  = 1'b1;
          end
        end
        sms_pkg::OP_RELEASE: coils_nxt = '0;
        sms_pkg::OP_LOAD:    pos_nxt   = item.new_position;
        default: ;
      endcase
    end

    p = sms_pkg::next_phase(phase_r, step_dir, cfg.half_step_mode);
    if (do_step) begin
      phase_nxt = p;
      coils_nxt = sms_pkg::coil_pattern(p, cfg.half_step_mode);
      pos_nxt   = step_dir ? pos_r - sms_pkg::POSITION_BITS'(1)
                           : pos_r + sms_pkg::POSITION_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      coils_r <= '0;
      pos_r   <= '0;
      steps_r <= '0;
      delay_r <= '0;
      dir_r   <= 1'b0;
      busy_r  <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      coils_r <= coils_nxt;
      pos_r   <= pos_nxt;
      steps_r <= steps_nxt;
      delay_r <= delay_nxt;
      dir_r   <= dir_nxt;
      busy_r  <= busy_nxt;
    end
  end

  assign res.coils        = coils_nxt;
  assign res.position_now = pos_nxt;
  assign res.moving       = busy_nxt;
  assign res.status       = status;

endmodule

>>> rtl/stepper_move_sequencer.sv
// top level: command register, motor state core, result register, config registers
// Unipolar stepper sequencer in half-step or full-step mode. Each command beat
// (tick, move, release, load position) yields exactly one result beat with the
// coil levels, position, moving flag and reject status after that command. A beat
// is held in an input register and processed in one pass into the result
// register, so the block takes one beat per clock cycle while results are taken;
// with the result register full and not taken, one more command waits in the
// input register before ready drops. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce this.
// Configuration takes effect from the next step or delay reload.
module stepper_move_sequencer (
  input  logic                               clk,
  input  logic                               rst_n,
  sms_in_if.sink                             in_ch,
  sms_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [sms_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [sms_pkg::DELAY_BITS-1:0]     cfg_wdata
);

  logic             in_valid_r;
  sms_pkg::item_t   item_r;
  logic             out_valid_r;
  sms_pkg::result_t res_r;
  sms_pkg::result_t res_nxt;
  sms_pkg::cfg_t    cfg_r;
  logic             out_free;
  logic             fire;
  logic             in_take;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign fire        = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || out_free;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op           <= in_ch.op;
      item_r.move_steps   <= in_ch.move_steps;
      item_r.new_position <= in_ch.new_position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_step_mode   <= 1'b0;
      cfg_r.step_delay_ticks <= sms_pkg::DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sms_pkg::CFG_HALF_STEP: cfg_r.half_step_mode   <= cfg_wdata[0];
        sms_pkg::CFG_DELAY:     cfg_r.step_delay_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

  sms_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg_r),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.coils        = res_r.coils;
  assign out_ch.position_now = res_r.position_now;
  assign out_ch.moving       = res_r.moving;
  assign out_ch.status       = res_r.status;

endmodule

>>> sim/tb_stepper_move_sequencer.sv
// testbench for stepper_move_sequencer: directed table plus random commands vs a predictor
module tb_stepper_move_sequencer;
  import sms_pkg::*;

  localparam int RANDOM_ITEMS = 1050;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_LIMIT  = 20000;

  localparam logic [COIL_BITS-1:0] HALF_COILS [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };
  localparam logic [COIL_BITS-1:0] FULL_COILS [4] = '{4'h3, 4'h6, 4'hC, 4'h9};

  typedef enum logic [1:0] {ROW_CMD, ROW_CFG, ROW_SETTLE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    item_t                 cmd;
    logic                  typed;
    result_t               want;
    logic                  half;
    logic [DELAY_BITS-1:0] dly;
  } plan_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [DELAY_BITS-1:0]   cfg_wdata;

  sms_in_if  in_ch();
  sms_out_if out_ch();

  stepper_move_sequencer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // motor predictor state
  logic                            mot_half;
  logic [DELAY_BITS-1:0]           mot_delay;
  logic [PHASE_BITS-1:0]           mot_phase;
  logic [COIL_BITS-1:0]            mot_coils;
  logic signed [POSITION_BITS-1:0] mot_pos;
  logic [STEPS_BITS-1:0]           mot_steps_left;
  logic [DELAY_BITS-1:0]           mot_delay_left;
  logic                            mot_dir;
  logic                            mot_busy;

  result_t   due_reports [$];
  plan_row_t plan [$];
  int        mismatches;
  int        burst_left;
  bit        gaps_on;
  bit        hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [DELAY_BITS-1:0] reload_delay();
    return (mot_delay == '0) ? DELAY_BITS'(1) : mot_delay;
  endfunction

  function automatic void take_motor_step();
    int count;
    int p;
    count = mot_half ? 8 : 4;
    p = int'(mot_phase);
    if (!mot_dir) begin
      p = p + 1;
      if (p >= count) p = 0;
    end else if (p == 0) begin
      p = count - 1;
    end else begin
      p = p - 1;
      if (p >= count) p = 0;
    end
    mot_phase = p[PHASE_BITS-1:0];
    mot_coils = mot_half ? HALF_COILS[p] : FULL_COILS[p % 4];
    mot_pos = mot_dir ? mot_pos - 1 : mot_pos + 1;
  endfunction

  function automatic result_t predict_motor(input item_t cmd);
    result_t    r;
    logic [31:0] mag;
    logic       rejected;
    rejected = 1'b0;
    if (cmd.op == OP_TICK) begin
      if (mot_busy) begin
        if (mot_delay_left != '0) mot_delay_left = mot_delay_left - 1'b1;
        if (mot_delay_left == '0) begin
          if (mot_steps_left != '0) begin
            take_motor_step();
            mot_steps_left = mot_steps_left - 1'b1;
            mot_delay_left = reload_delay();
          end else begin
            mot_busy = 1'b0;
          end
        end
      end
    end else if (mot_busy) begin
      rejected = 1'b1;
    end else if (cmd.op == OP_MOVE) begin
      if (cmd.move_steps != 0) begin
        mot_dir = cmd.move_steps[31];
        mag = cmd.move_steps[31] ? 32'(-cmd.move_steps) : 32'(cmd.move_steps);
        take_motor_step();
        mot_steps_left = STEPS_BITS'(mag - 1);
        mot_delay_left = reload_delay();
        mot_busy = 1'b1;
      end
    end else if (cmd.op == OP_RELEASE) begin
      mot_coils = '0;
    end else begin
      mot_pos = cmd.new_position;
    end
    r.coils        = mot_coils;
    r.position_now = mot_pos;
    r.moving       = mot_busy;
    r.status       = rejected;
    return r;
  endfunction

  function automatic plan_row_t cmd_row(input logic [1:0] op, input logic [31:0] steps,
                                        input logic [31:0] position);
    plan_row_t r;
    r.kind  = ROW_CMD;
    r.cmd.op = op;
    r.cmd.move_steps = steps;
    r.cmd.new_position = position;
    r.typed = 1'b0;
    r.want  = '0;
    r.half  = 1'b0;
    r.dly   = '0;
    return r;
  endfunction

  function automatic plan_row_t chk_row(input logic [1:0] op, input logic [31:0] steps,
                                        input logic [31:0] position, input logic [3:0] coils,
                                        input logic [31:0] pos_now, input logic moving,
                                        input logic status);
    plan_row_t r;
    r = cmd_row(op, steps, position);
    r.typed = 1'b1;
    r.want  = {coils, pos_now, moving, status};
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic half, input logic [DELAY_BITS-1:0] dly);
    plan_row_t r;
    r = cmd_row(OP_TICK, '0, '0);
    r.kind = ROW_CFG;
    r.half = half;
    r.dly  = dly;
    return r;
  endfunction

  function automatic plan_row_t settle_row();
    plan_row_t r;
    r = cmd_row(OP_TICK, '0, '0);
    r.kind = ROW_SETTLE;
    return r;
  endfunction

  task automatic send_cmd(input item_t cmd, input logic typed, input result_t want);
    result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.op           <= cmd.op;
    in_ch.move_steps   <= cmd.move_steps;
    in_ch.new_position <= cmd.new_position;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = predict_motor(cmd);
    due_reports.push_back(typed ? want : r);
  endtask

  // registers change only with the command channel drained
  task automatic apply_config(input logic half, input logic [DELAY_BITS-1:0] dly);
    in_ch.valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HALF_STEP;
    cfg_wdata <= DELAY_BITS'(half);
    @(posedge clk);
    cfg_index <= CFG_DELAY;
    cfg_wdata <= dly;
    @(posedge clk);
    cfg_we <= 1'b0;
    mot_half   = half;
    mot_delay  = dly;
    burst_left = 0;
  endtask

  task automatic check_report(input result_t got);
    result_t want;
    if (due_reports.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected beat: coils=%h pos=%0d moving=%b status=%b",
                 got.coils, got.position_now, got.moving, got.status);
    end else begin
      want = due_reports.pop_front();
      if (got.coils !== want.coils || got.position_now !== want.position_now ||
          got.moving !== want.moving || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp coils=%h pos=%0d moving=%b status=%b",
                   want.coils, want.position_now, want.moving, want.status);
          $display("          got coils=%h pos=%0d moving=%b status=%b",
                   got.coils, got.position_now, got.moving, got.status);
        end
      end
    end
  endtask

  initial begin : result_sink
    logic [7:0] stall_mask;
    int         mask_age;
    int         hold_left;
    int         slot;
    out_ch.ready <= 1'b0;
    stall_mask = 8'hFF;
    mask_age   = 0;
    hold_left  = 0;
    slot       = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        check_report({out_ch.coils, out_ch.position_now, out_ch.moving, out_ch.status});
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (mask_age == 0) begin
        mask_age = $urandom_range(16, 96);
        if ($urandom_range(0, 3) == 0) stall_mask = 8'hFF;
        else stall_mask = 8'($urandom) | 8'h01;
      end
      mask_age--;
      slot = (slot + 1) % 8;
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= stall_mask[slot];
      end
    end
  end

  initial begin : command_source
    item_t      cmd;
    item_t      tick_cmd;
    int         rand_sent;
    int         phase_no;
    int         n;
    int         pick;
    int         mag;
    int         guard;
    logic [DELAY_BITS-1:0] dly;

    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.op           <= OP_TICK;
    in_ch.move_steps   <= '0;
    in_ch.new_position <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_HALF_STEP;
    cfg_wdata          <= '0;

    mot_half       = 1'b0;
    mot_delay      = DELAY_BITS'(2944);
    mot_phase      = '0;
    mot_coils      = '0;
    mot_pos        = '0;
    mot_steps_left = '0;
    mot_delay_left = '0;
    mot_dir        = 1'b0;
    mot_busy       = 1'b0;
    mismatches = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;
    tick_cmd   = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset config: full step; a short delay before the first move keeps the settle brief
    plan = '{
      chk_row(OP_TICK,    '0,           '0,           4'h0, 32'h0,        1'b0, 1'b0),
      chk_row(OP_RELEASE, '0,           '0,           4'h0, 32'h0,        1'b0, 1'b0),
      chk_row(OP_LOAD,    '0,           32'h7FFFFFFF, 4'h0, 32'h7FFFFFFF, 1'b0, 1'b0),
      chk_row(OP_MOVE,    32'h0,        32'hFFFFFFFF, 4'h0, 32'h7FFFFFFF, 1'b0, 1'b0),
      cfg_row(1'b0, 20'd4),
      chk_row(OP_MOVE,    32'h1,        '0,           4'h6, 32'h80000000, 1'b1, 1'b0),
      chk_row(OP_RELEASE, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'h6, 32'h80000000, 1'b1, 1'b1),
      chk_row(OP_LOAD,    '0,           32'h80000000, 4'h6, 32'h80000000, 1'b1, 1'b1),
      chk_row(OP_MOVE,    32'h7FFFFFFF, '0,           4'h6, 32'h80000000, 1'b1, 1'b1),
      chk_row(OP_MOVE,    32'h80000000, '0,           4'h6, 32'h80000000, 1'b1, 1'b1),
      settle_row(),
      cfg_row(1'b1, 20'd1),
      cmd_row(OP_MOVE,    32'hFFFFFFFD, '0),
      cmd_row(OP_RELEASE, '0,           '0),
      settle_row(),
      // full step with the phase left outside the four-entry table
      cfg_row(1'b0, 20'd0),
      cmd_row(OP_MOVE,    32'h2,        '0),
      settle_row(),
      cmd_row(OP_MOVE,    32'hFFFFFFFF, '0),
      settle_row(),
      cfg_row(1'b1, 20'd3),
      cmd_row(OP_LOAD,    '0,           32'h0),
      cmd_row(OP_RELEASE, '0,           '0),
      cmd_row(OP_TICK,    '0,           '0),
      cmd_row(OP_MOVE,    32'h5,        '0),
      // mode and delay switched mid-move
      cfg_row(1'b0, 20'd2),
      settle_row()
    };

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CMD:    send_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
        ROW_CFG:    apply_config(plan[i].half, plan[i].dly);
        ROW_SETTLE: while (mot_busy) send_cmd(tick_cmd, 1'b0, '0);
        default:    ;
      endcase
    end

    rand_sent = 0;
    phase_no  = 0;
    while (rand_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       dly = '0;
        1:       dly = DELAY_BITS'(1);
        5:       dly = DELAY_BITS'($urandom_range(5, 12));
        7:       dly = DELAY_BITS'($urandom_range(1, 3));
        default: dly = DELAY_BITS'($urandom_range(2, 4));
      endcase
      apply_config(1'($urandom_range(0, 1)), dly);
      gaps_on = ($urandom_range(0, 2) != 0);
      // receiver holds off while commands keep coming so the block backs up
      if (phase_no == 2) begin
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end
      n = $urandom_range(40, 120);
      repeat (n) begin
        cmd = '0;
        if (mot_busy) begin
          if ($urandom_range(0, 3) == 0) begin
            cmd.op           = 2'($urandom_range(1, 3));
            cmd.move_steps   = $urandom;
            cmd.new_position = $urandom;
          end
        end else begin
          pick = $urandom_range(0, 19);
          if (pick < 9) begin
            mag = (pick == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
            cmd.op         = OP_MOVE;
            cmd.move_steps = $urandom_range(0, 1) ? -mag : mag;
          end else if (pick < 11) begin
            cmd.op = OP_LOAD;
            case ($urandom_range(0, 3))
              0:       cmd.new_position = 32'h7FFFFFFF;
              1:       cmd.new_position = 32'h80000000;
              default: cmd.new_position = $urandom;
            endcase
          end else if (pick < 13) begin
            cmd.op = OP_RELEASE;
          end else if (pick == 13) begin
            cmd.op           = OP_MOVE;
            cmd.new_position = $urandom;
          end
        end
        send_cmd(cmd, 1'b0, '0);
        rand_sent++;
      end
      phase_no++;
    end

    // longest move and longest delay last: the block stays busy from here on
    apply_config(1'($urandom_range(0, 1)), 20'hFFFFF);
    cmd = '0;
    cmd.op         = OP_MOVE;
    cmd.move_steps = 32'h80000000;
    send_cmd(cmd, 1'b0, '0);
    repeat (24) begin
      cmd = '0;
      if ($urandom_range(0, 1) != 0) begin
        cmd.op           = 2'($urandom_range(1, 3));
        cmd.move_steps   = $urandom_range(0, 1) ? 32'h7FFFFFFF : $urandom;
        cmd.new_position = $urandom;
      end
      send_cmd(cmd, 1'b0, '0);
    end

    in_ch.valid <= 1'b0;
    for (guard = 0; guard < DRAIN_LIMIT && due_reports.size() != 0; guard++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (due_reports.size() != 0) begin
      mismatches += due_reports.size();
      $display("%0d expected beats never arrived", due_reports.size());
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
